// ===== hdl/tksel_pkg.sv =====
// Package with codes, types and command/status structs of the top-k gap selector.
`default_nettype none
package tksel_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int ENTRY_W      = 128;
  localparam int MAXK_RESET   = 64;

  typedef enum logic [1:0] {
    OP_INS_GIVEN = 2'd0,
    OP_INS_COMP  = 2'd1,
    OP_READ      = 2'd2,
    OP_CLEAR     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_KEPT = 2'd1,
    ST_NEG_GAP  = 2'd2,
    ST_RANK_OOB = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    div_start;
    logic    div_step;
    logic    idx_init;
    logic    pre_rd;
    logic    sh_rd;
    logic    wr_item;
    logic    wr_shift;
    logic    rd_rank;
    logic    clr_count;
    logic    commit;
    logic    finish;
    status_t fin_status;
    logic    fin_entry;
    logic    publish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    opcode_t op;
    logic    neg;
    logic    full;
    logic    count_zero;
    logic    rank_oob;
    logic    idx_zero;
    logic    rd_ge;
    logic    div_last;
    logic    out_busy;
  } stat_t;

endpackage
`default_nettype wire

// ===== hdl/tksel_if.sv =====
// Channel interfaces for requests, results and the configuration write.
`default_nettype none
interface tksel_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] sep_id;
  logic [15:0] pos_id;
  logic signed [31:0] gap_in;
  logic signed [31:0] violation;
  logic signed [31:0] rhs_b;
  logic [5:0]  rank;
  modport source (output valid, opcode, sep_id, pos_id, gap_in, violation, rhs_b, rank,
                  input ready);
  modport sink (input valid, opcode, sep_id, pos_id, gap_in, violation, rhs_b, rank,
                output ready);
endinterface

interface tksel_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [6:0]  count;
  logic [15:0] out_sep_id;
  logic [15:0] out_pos_id;
  logic [31:0] out_gap;
  logic signed [31:0] out_violation;
  logic signed [31:0] out_rhs_b;
  modport source (output valid, status, count, out_sep_id, out_pos_id, out_gap,
                  out_violation, out_rhs_b, input ready);
  modport sink (input valid, status, count, out_sep_id, out_pos_id, out_gap,
                out_violation, out_rhs_b, output ready);
endinterface

interface tksel_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/tksel_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tksel_ram #(
  parameter int W = 8,
  parameter int D = 2
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/tksel_ctrl.sv =====
// Controller state machine sequencing division, insertion shift, reads and results.
`default_nettype none
module tksel_ctrl
  import tksel_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t st,
  output cmd_t       cmd
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DISP  = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_INS   = 9'b000001000,
    S_PRE   = 9'b000010000,
    S_SH    = 9'b000100000,
    S_SHCHK = 9'b001000000,
    S_RDW   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and command decode.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (st.op)
          OP_CLEAR: begin
            cmd.clr_count  = 1'b1;
            cmd.finish     = 1'b1;
            cmd.fin_status = ST_OK;
            state_nxt      = S_FIN;
          end
          OP_READ: begin
            if (st.rank_oob) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_RANK_OOB;
              state_nxt      = S_FIN;
            end else begin
              cmd.rd_rank = 1'b1;
              state_nxt   = S_RDW;
            end
          end
          OP_INS_GIVEN: begin
            if (st.neg) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_NEG_GAP;
              state_nxt      = S_FIN;
            end else begin
              state_nxt = S_INS;
            end
          end
          OP_INS_COMP: begin
            if (st.neg) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_NEG_GAP;
              state_nxt      = S_FIN;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        // A full store with nothing held can never keep the new entry.
        if (st.full && st.count_zero) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_NOT_KEPT;
          state_nxt      = S_FIN;
        end else begin
          cmd.idx_init = 1'b1;
          cmd.pre_rd   = st.full;
          state_nxt    = st.full ? S_PRE : S_SH;
        end
      end
      S_PRE: begin
        // The last entry wins ties, so the new one would be the one dropped.
        if (st.rd_ge) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_NOT_KEPT;
          state_nxt      = S_FIN;
        end else begin
          state_nxt = S_SH;
        end
      end
      S_SH: begin
        if (st.idx_zero) begin
          cmd.wr_item    = 1'b1;
          cmd.commit     = 1'b1;
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_OK;
          state_nxt      = S_FIN;
        end else begin
          cmd.sh_rd = 1'b1;
          state_nxt = S_SHCHK;
        end
      end
      S_SHCHK: begin
        if (st.rd_ge) begin
          cmd.wr_item    = 1'b1;
          cmd.commit     = 1'b1;
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_OK;
          state_nxt      = S_FIN;
        end else begin
          cmd.wr_shift = 1'b1;
          state_nxt    = S_SH;
        end
      end
      S_RDW: begin
        cmd.finish     = 1'b1;
        cmd.fin_status = ST_OK;
        cmd.fin_entry  = 1'b1;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Memory writes only happen while an insert is being placed.
  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_item || cmd.wr_shift) |-> (state_r == S_SH || state_r == S_SHCHK))
    else $error("store written outside insertion");
  // A result is never published over one still waiting.
  a_pub_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> !st.out_busy)
    else $error("result overwritten");
  // After a request is taken the block works on it before taking another.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_ready)
    else $error("second request taken while busy");
endmodule
`default_nettype wire

// ===== hdl/tksel_dpath.sv =====
// Datapath: request registers, serial divider, entry store, count and result registers.
`default_nettype none
module tksel_dpath
  import tksel_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tksel_in_if.sink    in_ch,
  tksel_out_if.source out_ch,
  tksel_cfg_if.sink   cfg_ch,
  input  wire cmd_t   cmd,
  output stat_t       st
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Request registers.
  opcode_t     op_r;
  logic [15:0] sep_r, pos_r;
  logic [31:0] gap_r, gap_nxt, viol_r, rhs_r;
  logic [5:0]  rank_r;

  // Store control and configuration.
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [6:0]    maxk_r;

  // Serial divider: shifting dividend/quotient word and partial remainder.
  logic [47:0] dq_r, dq_nxt;
  logic [32:0] rem_r, rem_nxt, rem_sh;
  logic [31:0] mag_r;
  logic [5:0]  dcnt_r;

  // Pending and published result.
  status_t     res_status_r, out_status_r;
  logic [6:0]  res_count_r, out_count_r;
  logic [127:0] res_entry_r, out_entry_r;
  logic        out_valid_r;

  logic          we;
  logic [AW-1:0] raddr;
  logic [127:0]  wdata, rdata, item;
  logic          full;

  assign item = {sep_r, pos_r, gap_r, viol_r, rhs_r};
  assign full = (32'(count_r) >= 32'(maxk_r)) || (32'(count_r) >= CAPACITY);

  // Status toward the controller.
  always_comb begin
    st.op         = op_r;
    st.neg        = (op_r == OP_INS_COMP) ? viol_r[31] : gap_r[31];
    st.full       = full;
    st.count_zero = (count_r == '0);
    st.rank_oob   = (32'(rank_r) >= 32'(count_r));
    st.idx_zero   = (idx_r == '0);
    st.rd_ge      = (rdata[95:64] >= gap_r);
    st.div_last   = (dcnt_r == 6'd47);
    st.out_busy   = out_valid_r && !out_ch.ready;
  end

  // One restoring division step per cycle.
  always_comb begin
    rem_sh  = {rem_r[31:0], dq_r[47]};
    rem_nxt = rem_sh;
    dq_nxt  = {dq_r[46:0], 1'b0};
    if (rem_sh >= {1'b0, mag_r}) begin
      rem_nxt   = rem_sh - {1'b0, mag_r};
      dq_nxt[0] = 1'b1;
    end
  end

  // Gap: given value, or saturated quotient at the last step.
  always_comb begin
    gap_nxt = gap_r;
    if (cmd.load) begin
      gap_nxt = in_ch.gap_in;
    end else if (cmd.div_step && st.div_last) begin
      gap_nxt = (dq_nxt[47:32] != '0) ? 32'hFFFF_FFFF : dq_nxt[31:0];
    end
  end

  // Insert position walks down from the end of the list.
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_init) begin
      idx_nxt = full ? AW'(count_r - 1'b1) : AW'(count_r);
    end else if (cmd.wr_shift) begin
      idx_nxt = idx_r - 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clr_count) begin
      count_nxt = '0;
    end else if (cmd.commit && !full) begin
      count_nxt = count_r + 1'b1;
    end
  end

  // Store port selection.
  always_comb begin
    we    = cmd.wr_item || cmd.wr_shift;
    wdata = cmd.wr_shift ? rdata : item;
    raddr = idx_r - 1'b1;
    if (cmd.pre_rd) begin
      raddr = AW'(count_r - 1'b1);
    end else if (cmd.rd_rank) begin
      raddr = AW'(rank_r);
    end
  end

  tksel_ram #(.W(ENTRY_W), .D(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cfg_ch.ready = 1'b1;

  // Payload registers.
  always_ff @(posedge clk) begin
    gap_r <= gap_nxt;
    idx_r <= idx_nxt;
    if (cmd.load) begin
      op_r   <= opcode_t'(in_ch.opcode);
      sep_r  <= in_ch.sep_id;
      pos_r  <= in_ch.pos_id;
      viol_r <= in_ch.violation;
      rhs_r  <= in_ch.rhs_b;
      rank_r <= in_ch.rank;
    end
    if (cmd.div_start) begin
      dq_r   <= {viol_r, 16'h0000};
      rem_r  <= '0;
      mag_r  <= rhs_r[31] ? (~rhs_r + 32'd1) : rhs_r;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dq_r   <= dq_nxt;
      rem_r  <= rem_nxt;
      dcnt_r <= dcnt_r + 6'd1;
    end
    if (cmd.finish) begin
      res_status_r <= cmd.fin_status;
      res_count_r  <= 7'(count_nxt);
      res_entry_r  <= cmd.fin_entry ? rdata : '0;
    end
    if (cmd.publish) begin
      out_status_r <= res_status_r;
      out_count_r  <= res_count_r;
      out_entry_r  <= res_entry_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      maxk_r      <= 7'(MAXK_RESET);
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cfg_ch.valid) begin
        maxk_r <= cfg_ch.data;
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.count         = out_count_r;
  assign out_ch.out_sep_id    = out_entry_r[127:112];
  assign out_ch.out_pos_id    = out_entry_r[111:96];
  assign out_ch.out_gap       = out_entry_r[95:64];
  assign out_ch.out_violation = out_entry_r[63:32];
  assign out_ch.out_rhs_b     = out_entry_r[31:0];

  // The count never goes past the store depth.
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= CAPACITY)
    else $error("count above capacity");
  // The count only grows by one or is cleared.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (count_r == '0 || count_r == $past(count_r) + 1'b1))
    else $error("count jumped");
  // The count only falls when it is cleared.
  a_cnt_src: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r > count_nxt) |-> cmd.clr_count)
    else $error("count fell without clear");
endmodule
`default_nettype wire

// ===== hdl/top_k_gap_ranked_selector_unit.sv =====
// Top level of the bounded top-k gap selector: controller plus datapath.
// Flow: a computed-gap insert first runs the serial divider; an insert then shifts entries
// down from the end of the list until it lands; every result waits for a free output.
// Requests: one at a time; the next is taken only once the result has been published,
// so the divider, the entry-by-entry shift through the store and a stalled output set the pace.
// Reset: synchronous active-low rst_n clears the count and output valid, sets max_kept to 64;
// the entry store is not cleared and needs no clearing pass.
`default_nettype none
module top_k_gap_ranked_selector_unit
  import tksel_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  tksel_in_if.sink    in_ch,
  tksel_out_if.source out_ch,
  tksel_cfg_if.sink   cfg_ch
);
  cmd_t  cmd;
  stat_t st;
  logic  in_rdy;

  tksel_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_rdy),
    .st       (st),
    .cmd      (cmd)
  );

  tksel_dpath #(.CAPACITY(CAPACITY)) u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .st     (st)
  );

  assign in_ch.ready = in_rdy;
endmodule
`default_nettype wire
